@@ design/olpd_pkg.sv @@
// package for the ordered list with positional delete
// holds sizes, command and status codes, cell operations and payload structs
// no dependencies
`default_nettype none

package olpd_pkg;

  // list capacity and derived widths
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned POS_W      = 16;

  // request command codes
  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_DEL_HEAD = 3'd1,
    CMD_DEL_TAIL = 3'd2,
    CMD_DEL_POS  = 3'd3,
    CMD_TRAVERSE = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_DONE    = 3'd0,
    STAT_EMPTY   = 3'd1,
    STAT_INVALID = 3'd2,
    STAT_BEYOND  = 3'd3,
    STAT_FULL    = 3'd4
  } status_e;

  // what a cell does: hold, load, shift or wrap
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_WRAP
  } cell_op_e;

  // control state of the top level
  typedef enum logic {
    ST_IDLE,
    ST_TRAV
  } state_e;

  // request payload
  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] element;
    logic                     element_valid;
    logic                     last;
  } out_rsp_t;

endpackage

`default_nettype wire

@@ design/ordered_list_positional_delete.sv @@
// top level of the ordered list with positional delete
// depends on olpd_pkg and olpd_cell
//
// Keeps up to LIST_DEPTH signed 32-bit entries in a chain of cells, head in
// cell 0. Append, delete head, delete tail and delete at a 1-based position
// each give a single status result: append loads one cell, delete head and
// delete at a position shift the cells behind the gap left in one step, and
// delete tail only lowers the count. Traverse rotates the occupied cells
// left once per result and emits the head cell, ending in the original order;
// on an empty list it gives a single status result. A full output register
// that is not taken holds the rotation, and no new request is taken until
// the last element has been handed to the output register. Unused command
// codes are taken and give no result. The output register lets a new request
// in while the previous result is being taken.
`default_nettype none

module ordered_list_positional_delete (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire olpd_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output olpd_pkg::out_rsp_t      out_rsp_o
);
  import olpd_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   trav_q, trav_d;
  logic               out_valid_q, out_valid_d;
  out_rsp_t           out_q, out_d;
  logic               out_load;

  logic               in_fire;
  logic               out_free;
  logic               list_empty;
  logic               list_full;
  logic               trav_last;
  cmd_e               cmd;

  cell_op_e                 cell_op   [LIST_DEPTH];
  logic signed [DATA_W-1:0] cell_data [LIST_DEPTH];

  assign cmd        = cmd_e'(in_req_i.command);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign list_empty = (cnt_q == '0);
  assign list_full  = (cnt_q == CNT_W'(LIST_DEPTH));
  assign trav_last  = ({1'b0, trav_q} == CNT_W'(cnt_q - 1'b1));

  // chain of cells
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] next_value;
    if (g < LIST_DEPTH - 1) begin : g_mid
      assign next_value = cell_data[g+1];
    end else begin : g_end
      assign next_value = cell_data[g];
    end
    olpd_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (cell_op[g]),
      .load_value_i (in_req_i.value),
      .next_value_i (next_value),
      .head_value_i (cell_data[0]),
      .data_o       (cell_data[g])
    );
  end

  // per-cell operation for the current cycle
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (state_q == ST_TRAV) begin
        if (out_free) begin
          if (CNT_W'(i) == CNT_W'(cnt_q - 1'b1)) begin
            cell_op[i] = CELL_WRAP;
          end else if (CNT_W'(i) < cnt_q) begin
            cell_op[i] = CELL_SHIFT;
          end
        end
      end else if (in_fire) begin
        case (cmd)
          CMD_APPEND: begin
            if (!list_full && CNT_W'(i) == cnt_q) cell_op[i] = CELL_LOAD;
          end
          CMD_DEL_HEAD: begin
            if (!list_empty) cell_op[i] = CELL_SHIFT;
          end
          CMD_DEL_POS: begin
            if (!list_empty && in_req_i.position != '0
                && {{(POS_W-CNT_W){1'b0}}, cnt_q} >= in_req_i.position
                && (i + 1) >= int'(in_req_i.position)) begin
              cell_op[i] = CELL_SHIFT;
            end
          end
          default: cell_op[i] = CELL_HOLD;
        endcase
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && cmd == CMD_TRAVERSE && !list_empty) state_d = ST_TRAV;
      end
      ST_TRAV: begin
        if (out_free && trav_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result register, count and traverse index
  always_comb begin
    out_load = 1'b0;
    out_d    = out_q;
    cnt_d    = cnt_q;
    trav_d   = trav_q;
    case (state_q)
      ST_IDLE: begin
        out_d.element       = '0;
        out_d.element_valid = 1'b0;
        out_d.last          = 1'b1;
        out_d.status        = STAT_DONE;
        trav_d              = '0;
        if (in_fire) begin
          case (cmd)
            CMD_APPEND: begin
              out_load = 1'b1;
              if (list_full) out_d.status = STAT_FULL;
              else cnt_d = cnt_q + 1'b1;
            end
            CMD_DEL_HEAD, CMD_DEL_TAIL: begin
              out_load = 1'b1;
              if (list_empty) out_d.status = STAT_EMPTY;
              else cnt_d = cnt_q - 1'b1;
            end
            CMD_DEL_POS: begin
              out_load = 1'b1;
              if (list_empty) begin
                out_d.status = STAT_EMPTY;
              end else if (in_req_i.position == '0) begin
                out_d.status = STAT_INVALID;
              end else if (in_req_i.position > {{(POS_W-CNT_W){1'b0}}, cnt_q}) begin
                out_d.status = STAT_BEYOND;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            CMD_TRAVERSE: begin
              out_load = list_empty;
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      ST_TRAV: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_d.status        = STAT_DONE;
          out_d.element       = cell_data[0];
          out_d.element_valid = 1'b1;
          out_d.last          = trav_last;
          trav_d              = trav_q + 1'b1;
        end
      end
      default: out_load = 1'b0;
    endcase
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      trav_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      trav_q      <= trav_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LIST_DEPTH))
    else $error("entry count above capacity");

  // a traverse of a non-empty list enters the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd == CMD_TRAVERSE && !list_empty) |=> (state_q == ST_TRAV))
    else $error("traverse did not start");

  // no request is taken while elements are being emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRAV) |-> !in_ready_o)
    else $error("request taken during traverse");

  // the entry count is unchanged across a whole traverse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRAV) |=> $stable(cnt_q))
    else $error("count changed during traverse");

endmodule

`default_nettype wire

@@ design/olpd_cell.sv @@
// one storage cell of the list chain
// depends on olpd_pkg for the cell operation codes and data width
`default_nettype none

module olpd_cell (
  input  wire logic                              clk_i,
  input  wire olpd_pkg::cell_op_e                op_i,
  input  wire logic signed [olpd_pkg::DATA_W-1:0] load_value_i,
  input  wire logic signed [olpd_pkg::DATA_W-1:0] next_value_i,
  input  wire logic signed [olpd_pkg::DATA_W-1:0] head_value_i,
  output logic signed [olpd_pkg::DATA_W-1:0]      data_o
);
  import olpd_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;

  // pick the new entry: appended value, right neighbor, or head on wrap
  always_comb begin
    case (op_i)
      CELL_LOAD:  data_d = load_value_i;
      CELL_SHIFT: data_d = next_value_i;
      CELL_WRAP:  data_d = head_value_i;
      default:    data_d = data_q;
    endcase
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ dv/ordered_list_positional_delete_test.sv @@
// self-checking testbench for the ordered list with positional delete
// depends on olpd_pkg and the ordered_list_positional_delete top level
// a shadow list predicts every result; random gaps and stalls on both channels
`default_nettype none

module ordered_list_positional_delete_test;
  timeunit 1ns;
  timeprecision 1ps;

  import olpd_pkg::*;

  // run sizing
  localparam int unsigned RANDOM_ITEMS   = 150;
  localparam int unsigned HOLD_OFF_AFTER = 60;
  localparam int unsigned HOLD_OFF_LEN   = 150;
  localparam int unsigned DRAIN_CYCLES   = 2 * LIST_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned PRINT_CAP      = 100;

  // first command code the block does not decode
  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;

  // shadow of the list contents plus the queue of results still due
  class list_shadow;
    logic signed [DATA_W-1:0] entries [LIST_DEPTH];
    int unsigned              count;
    out_rsp_t                 due_results [$];
    int unsigned              mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    // one line per mismatch, counted even when printing is capped
    task flag_mismatch(string msg);
      if (mismatches < PRINT_CAP) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    // drop one slot and close the gap behind it
    function void close_gap(int unsigned idx);
      int unsigned i;
      for (i = idx; i + 1 < count; i++) begin
        entries[i] = entries[i + 1];
      end
      count--;
    endfunction

    function void push_status(status_e st);
      out_rsp_t rsp;
      rsp.status        = st;
      rsp.element       = '0;
      rsp.element_valid = 1'b0;
      rsp.last          = 1'b1;
      due_results.push_back(rsp);
    endfunction

    // update the shadow for an accepted request and queue its results
    function void apply_request(in_req_t req);
      out_rsp_t    rsp;
      int unsigned i;
      case (req.command)
        CMD_APPEND: begin
          if (count >= LIST_DEPTH) begin
            push_status(STAT_FULL);
          end else begin
            entries[count] = req.value;
            count++;
            push_status(STAT_DONE);
          end
        end
        CMD_DEL_HEAD: begin
          if (count == 0) begin
            push_status(STAT_EMPTY);
          end else begin
            close_gap(0);
            push_status(STAT_DONE);
          end
        end
        CMD_DEL_TAIL: begin
          if (count == 0) begin
            push_status(STAT_EMPTY);
          end else begin
            count--;
            push_status(STAT_DONE);
          end
        end
        CMD_DEL_POS: begin
          if (count == 0) begin
            push_status(STAT_EMPTY);
          end else if (req.position == '0) begin
            push_status(STAT_INVALID);
          end else if (int'(req.position) > int'(count)) begin
            push_status(STAT_BEYOND);
          end else begin
            close_gap(int'(req.position) - 1);
            push_status(STAT_DONE);
          end
        end
        CMD_TRAVERSE: begin
          if (count == 0) begin
            push_status(STAT_DONE);
          end else begin
            for (i = 0; i < count; i++) begin
              rsp.status        = STAT_DONE;
              rsp.element       = entries[i];
              rsp.element_valid = 1'b1;
              rsp.last          = (i + 1 == count);
              due_results.push_back(rsp);
            end
          end
        end
        default: begin
          // unused codes are swallowed with no result
        end
      endcase
    endfunction

    // compare one accepted result with the oldest one due
    task take_result(out_rsp_t got);
      out_rsp_t want;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d element %0d",
                                got.status, got.element));
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status)
        flag_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.element !== want.element)
        flag_mismatch($sformatf("element got %0d want %0d", got.element, want.element));
      if (got.element_valid !== want.element_valid)
        flag_mismatch($sformatf("element_valid got %0b want %0b",
                                got.element_valid, want.element_valid));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

  // block inputs, all known from time zero
  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  in_req_t  in_req_i    = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  out_rsp_t out_rsp_o;

  list_shadow  shadow = new();
  int unsigned requests_taken = 0;
  int unsigned cycle_count = 0;

  ordered_list_positional_delete uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // idle lengths: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_req_t make_req(logic [2:0] cmd, logic signed [DATA_W-1:0] val,
                                       logic [POS_W-1:0] pos);
    in_req_t req;
    req.command  = cmd;
    req.value    = val;
    req.position = pos;
    return req;
  endfunction

  // offer one request after an optional gap, hold it until taken
  task automatic offer_request(in_req_t req, int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.apply_request(req);
    requests_taken++;
  endtask

  // position for a delete: mostly in range, some zero, past the tail or wild
  function automatic logic [POS_W-1:0] pick_position(int unsigned cnt);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return POS_W'($urandom);
    if (r < 32) return POS_W'(cnt + 1);
    if (r < 38) return POS_W'(cnt + $urandom_range(1, 5));
    return POS_W'($urandom_range(1, (cnt == 0) ? 1 : cnt));
  endfunction

  // edge cases: empty list, extremes, full list, bad positions
  task automatic run_directed();
    int unsigned i;
    logic signed [DATA_W-1:0] val;
    offer_request(make_req(CMD_TRAVERSE, '0, '0), pick_gap());
    offer_request(make_req(CMD_DEL_HEAD, '0, '0), pick_gap());
    offer_request(make_req(CMD_DEL_TAIL, '0, '0), pick_gap());
    offer_request(make_req(CMD_DEL_POS, '0, '0), pick_gap());
    offer_request(make_req(CMD_DEL_POS, '0, '1), pick_gap());
    for (i = 0; i < LIST_DEPTH; i++) begin
      case (i)
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7fff_ffff;
        2:       val = '0;
        3:       val = -32'sd1;
        default: val = $urandom;
      endcase
      offer_request(make_req(CMD_APPEND, val, '0), pick_gap());
    end
    offer_request(make_req(CMD_APPEND, $urandom, '0), pick_gap());
    offer_request(make_req(CMD_TRAVERSE, '0, '0), pick_gap());
    offer_request(make_req(CMD_DEL_POS, '0, '0), pick_gap());
    offer_request(make_req(CMD_DEL_POS, '0, '1), pick_gap());
    offer_request(make_req(CMD_DEL_POS, '0, POS_W'(LIST_DEPTH)), pick_gap());
    offer_request(make_req(CMD_DEL_POS, '0, POS_W'(7)), pick_gap());
    offer_request(make_req(CMD_TRAVERSE, '0, '0), pick_gap());
  endtask

  // random traffic that swings the list between empty and full
  task automatic run_random();
    int unsigned counted;
    int unsigned cnt;
    int unsigned r;
    int unsigned d;
    bit          filling;
    in_req_t     req;
    counted = 0;
    filling = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      cnt = shadow.count;
      if (cnt >= LIST_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (cnt == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      else if ($urandom_range(0, 29) == 0) filling = !filling;
      req = make_req(CMD_APPEND, $urandom, POS_W'($urandom));
      r = $urandom_range(0, 99);
      if (r < 4) begin
        req.command = CMD_FIRST_UNUSED + 3'($urandom_range(0, 2));
      end else if (r < 14) begin
        req.command = CMD_TRAVERSE;
      end else if (r < (filling ? 66 : 30)) begin
        req.command = CMD_APPEND;
      end else begin
        d = $urandom_range(0, 9);
        if (d < 2) begin
          req.command = CMD_DEL_HEAD;
        end else if (d < 4) begin
          req.command = CMD_DEL_TAIL;
        end else begin
          req.command  = CMD_DEL_POS;
          req.position = pick_position(cnt);
        end
      end
      offer_request(req, pick_gap());
      if (req.command <= CMD_TRAVERSE) counted++;
    end
  endtask

  // result side: wait for a clock edge and check a result taken at it
  task automatic sink_cycle();
    @(posedge clk_i);
    if (out_valid_o && out_ready_i) shadow.take_result(out_rsp_o);
  endtask

  // result side: random stalls, plus one long hold-off while requests keep coming
  initial begin : result_sink
    int unsigned stall;
    int unsigned burst;
    bit          held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && requests_taken >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        stall    = HOLD_OFF_LEN;
      end else begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) sink_cycle();
      end
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      out_ready_i <= 1'b1;
      repeat (burst) sink_cycle();
    end
  end

  // cycle limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // reset, stimulus, drain and verdict
  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.due_results.size() != 0) begin
      shadow.flag_mismatch($sformatf("%0d results never arrived",
                                     shadow.due_results.size()));
    end
    if (shadow.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
